// File: design/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg - shared types and constants for the sorted list merger
// Controller states, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int DefaultListDepth = 16;
   localparam int ValueWidth       = 32;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // input words may be accepted
      logic emit;   // move the chosen head into the output register
      logic clear;  // empty both lists after this emit
   } cmd_type;

   typedef struct packed {
      logic pair_close;  // the offered word closes the second open list
      logic out_free;    // output register can take a word
      logic last_pick;   // the current pick is the final one of the burst
   } status_type;

endpackage

// File: design/slm_ram.sv
// ----------------------------------------------------------------------------
// slm_ram - generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl - sequencer for the sorted list merger
// Loads words until both lists close, then steps the merge one pick at a time.
// ----------------------------------------------------------------------------
module slm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  slm_pkg::status_type status,
   output slm_pkg::cmd_type    cmd
);
   import slm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.pair_close) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_pick ? ST_LOAD : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_FETCH: begin
            cmd = '0;
         end
         ST_EMIT: begin
            cmd.emit  = status.out_free;
            cmd.clear = status.out_free & status.last_pick;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/slm_dp.sv
// ----------------------------------------------------------------------------
// slm_dp - datapath of the sorted list merger
// List stores, fill counts, merge indices, head compare, output register.
// ----------------------------------------------------------------------------
module slm_dp #(
   parameter int LIST_DEPTH = slm_pkg::DefaultListDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  slm_pkg::cmd_type                 cmd,
   output slm_pkg::status_type              status,
   input  logic                             req_valid,
   input  logic                             req_list_sel,
   input  logic signed [slm_pkg::ValueWidth-1:0] req_elem_value,
   input  logic                             req_list_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [slm_pkg::ValueWidth-1:0] rsp_merged_value,
   output logic                             rsp_source_list,
   output logic                             rsp_burst_last,
   output logic                             rsp_overflow_flag
);
   import slm_pkg::*;

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CW-1:0] DepthCount = CW'(LIST_DEPTH);

   logic [CW-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [CW-1:0] idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic          closed1_ff, closed1_in, closed2_ff, closed2_in;
   logic          dropped_ff, dropped_in;
   logic          load_fire, wr1, wr2;
   logic [ValueWidth-1:0] head1, head2;
   logic          done1, done2, pick_second;
   logic [CW:0]   pick_sum, total;

   logic                  out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0] out_value_ff;
   logic                  out_src_ff, out_last_ff, out_ovf_ff;

   assign load_fire = cmd.load & req_valid;
   assign wr1 = load_fire & ~req_list_sel & ~closed1_ff & (cnt1_ff < DepthCount);
   assign wr2 = load_fire &  req_list_sel & ~closed2_ff & (cnt2_ff < DepthCount);

   slm_ram #(.WIDTH(ValueWidth), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr1),
      .wr_addr (cnt1_ff[AW-1:0]),
      .wr_data (req_elem_value),
      .rd_addr (idx1_ff[AW-1:0]),
      .rd_data (head1)
   );

   slm_ram #(.WIDTH(ValueWidth), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram2 (
      .clock   (clock),
      .wr_en   (wr2),
      .wr_addr (cnt2_ff[AW-1:0]),
      .wr_data (req_elem_value),
      .rd_addr (idx2_ff[AW-1:0]),
      .rd_data (head2)
   );

   assign done1 = (idx1_ff >= cnt1_ff);
   assign done2 = (idx2_ff >= cnt2_ff);
   // tie goes to the second list
   assign pick_second = done1 | (~done2 & ~($signed(head1) < $signed(head2)));
   assign pick_sum = {1'b0, idx1_ff} + {1'b0, idx2_ff} + {{CW{1'b0}}, 1'b1};
   assign total    = {1'b0, cnt1_ff} + {1'b0, cnt2_ff};

   always_comb begin
      cnt1_in    = cnt1_ff;
      cnt2_in    = cnt2_ff;
      closed1_in = closed1_ff;
      closed2_in = closed2_ff;
      dropped_in = dropped_ff;
      idx1_in    = idx1_ff;
      idx2_in    = idx2_ff;
      if (load_fire) begin
         if (!req_list_sel) begin
            if (closed1_ff) begin
               dropped_in = 1'b1;
            end else begin
               if (wr1) begin
                  cnt1_in = cnt1_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_list_end) begin
                  closed1_in = 1'b1;
               end
            end
         end else begin
            if (closed2_ff) begin
               dropped_in = 1'b1;
            end else begin
               if (wr2) begin
                  cnt2_in = cnt2_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_list_end) begin
                  closed2_in = 1'b1;
               end
            end
         end
      end
      if (cmd.emit) begin
         if (pick_second) begin
            idx2_in = idx2_ff + CW'(1);
         end else begin
            idx1_in = idx1_ff + CW'(1);
         end
      end
      if (cmd.clear) begin
         cnt1_in    = '0;
         cnt2_in    = '0;
         closed1_in = 1'b0;
         closed2_in = 1'b0;
         dropped_in = 1'b0;
         idx1_in    = '0;
         idx2_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff    <= '0;
         cnt2_ff    <= '0;
         closed1_ff <= 1'b0;
         closed2_ff <= 1'b0;
         dropped_ff <= 1'b0;
         idx1_ff    <= '0;
         idx2_ff    <= '0;
      end else begin
         cnt1_ff    <= cnt1_in;
         cnt2_ff    <= cnt2_in;
         closed1_ff <= closed1_in;
         closed2_ff <= closed2_in;
         dropped_ff <= dropped_in;
         idx1_ff    <= idx1_in;
         idx2_ff    <= idx2_in;
      end
   end

   // output word register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff <= pick_second ? head2 : head1;
         out_src_ff   <= pick_second;
         out_last_ff  <= (pick_sum == total);
         out_ovf_ff   <= dropped_ff;
      end
   end

   // offered word closes the pair; the controller qualifies it with req_valid
   assign status.pair_close = (closed1_ff | (~req_list_sel & req_list_end)) &
                              (closed2_ff | ( req_list_sel & req_list_end));
   assign status.out_free   = ~out_valid_ff | rsp_ready;
   assign status.last_pick  = (pick_sum == total);

   assign rsp_valid         = out_valid_ff;
   assign rsp_merged_value  = out_value_ff;
   assign rsp_source_list   = out_src_ff;
   assign rsp_burst_last    = out_last_ff;
   assign rsp_overflow_flag = out_ovf_ff;

endmodule

// File: design/sorted_list_merger.sv
// After the word that closes the second list, each merged word takes a store read
// (ST_FETCH) and then a pick (ST_EMIT) that waits until the output register is free.
// Loading accepts one input word per cycle; inputs stall during the merge burst.
// Burst length is the sum of both fill counts, LIST_DEPTH each at most.
// Reset (synchronous): both lists empty and open, no word pending; store
// contents are left as they are and are only read below the fill counts.
// ----------------------------------------------------------------------------
// sorted_list_merger - merge of two ascending signed lists
// Loads two lists into RAM stores, then emits their ascending merge.
// ----------------------------------------------------------------------------
module sorted_list_merger #(
   parameter int LIST_DEPTH = slm_pkg::DefaultListDepth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_list_sel,
   input  logic signed [slm_pkg::ValueWidth-1:0] req_elem_value,
   input  logic                                  req_list_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [slm_pkg::ValueWidth-1:0] rsp_merged_value,
   output logic                                  rsp_source_list,
   output logic                                  rsp_burst_last,
   output logic                                  rsp_overflow_flag
);
   import slm_pkg::*;

   cmd_type    cmd;
   status_type status;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   slm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_valid         (req_valid),
      .req_list_sel      (req_list_sel),
      .req_elem_value    (req_elem_value),
      .req_list_end      (req_list_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_merged_value  (rsp_merged_value),
      .rsp_source_list   (rsp_source_list),
      .rsp_burst_last    (rsp_burst_last),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

   assign req_ready = cmd.load;

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("merge pick overwrote a pending word");

   a_no_load_in_merge: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.emit)
      else $error("load and merge active together");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> cmd.emit && status.last_pick)
      else $error("lists cleared outside the final pick");

   a_reload_after_burst: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> req_ready && rsp_valid && rsp_burst_last)
      else $error("burst end did not return to loading");
`endif

endmodule
